/* hdl/ssi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssi_pkg
// Widths, stage records and helpers for the segment / sphere intersect unit.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int CW    = 32;          // coordinate width, Q16.16
    localparam int EW    = 31;          // half-length and radius width
    localparam int DW    = CW + 1;      // centre difference
    localparam int A0W   = 68;          // d.d - r*r, Q32.32
    localparam int DOTW  = 66;          // dir.d, Q18.46
    localparam int A1W   = DOTW - 29;   // dir.d rounded to Q16.16
    localparam int ALW   = 18;          // low slice of A1 for the split products
    localparam int AHW   = A1W - ALW;   // signed high slice of A1
    localparam int DSW   = 2 * A1W + 1; // discriminant
    localparam int QW    = 72;          // endpoint tests
    localparam int SQW   = 70;          // square root operand
    localparam int NSQ   = SQW / 2;     // one root bit per stage
    localparam int RTW   = NSQ;         // root width
    localparam int REMW  = RTW + 3;     // partial remainder
    localparam int TW    = A1W + 2;     // unsaturated parameter
    localparam int PW    = 2 * CW;      // parameter times direction

    localparam logic [CW-1:0] THR_RESET = 32'd4295;
    localparam logic [1:0] HITS_NONE = 2'd0;
    localparam logic [1:0] HITS_ONE  = 2'd1;
    localparam logic [1:0] HITS_TWO  = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic signed [CW-1:0] oz;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] dz;
        logic [EW-1:0]        e;
    } t_geo;

    typedef struct packed {
        logic signed [A1W-1:0] a1;
        logic                  dneg;
        logic                  thr_ok;
        logic                  qm_zero;
        logic                  qm_neg;
        logic                  qp_zero;
        logic                  qp_neg;
    } t_cls;

    function automatic logic signed [CW-1:0] sat32(input logic signed [TW-1:0] x);
        logic same;
        same = (&x[TW-1:CW-1]) || !(|x[TW-1:CW-1]);
        if (same) return x[CW-1:0];
        else if (x[TW-1]) return {1'b1, {(CW-1){1'b0}}};
        else return {1'b0, {(CW-1){1'b1}}};
    endfunction

    // centre + round(t * dir), rounded half up as the Q18.46 to Q16.16 step
    function automatic logic signed [CW-1:0] hit_point(input logic signed [CW-1:0] org,
                                                       input logic signed [PW-1:0] p);
        logic signed [PW:0]      s;
        logic signed [PW-30:0]   rn;
        logic signed [TW-1:0]    sum;
        s   = (PW+1)'(p) + (PW+1)'(64'sd536870912);
        rn  = s[PW:30];
        sum = TW'(org) + TW'(rn);
        return sat32(sum);
    endfunction

endpackage

/* hdl/segment_sphere_intersect_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_sphere_intersect_unit
// Fixed-point segment against sphere test giving 0 to 2 hits per request.
// ----------------------------------------------------------------------------
// Usage:
//   A request (segment centre, direction, half-length, sphere centre and
//   radius) is taken on a rising edge with i_start high and o_busy low.
//   o_busy is always low: one request may enter every cycle.
//   Each request gives exactly one result, shown for one cycle with o_valid
//   high. Results leave in request order. Throughput is one request per
//   clock; the pipe is the 35-stage square root (one root bit per stage)
//   plus eight stages of quadratic set-up and three for hit selection and
//   point forming.
//   The receiver cannot stall; nothing is held back.
//   i_cfg_we / i_cfg_wdata write the discriminant tolerance; write it only
//   when no requests are in flight.
//   Reset (synchronous, active low) clears all stage valid bits, so no
//   result appears until new requests arrive; the tolerance returns to 4295.
// ----------------------------------------------------------------------------
module segment_sphere_intersect_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_cfg_we,
    input  logic [31:0]                  i_cfg_wdata,
    input  logic signed [31:0]           i_seg_center_x,
    input  logic signed [31:0]           i_seg_center_y,
    input  logic signed [31:0]           i_seg_center_z,
    input  logic signed [31:0]           i_dir_x,
    input  logic signed [31:0]           i_dir_y,
    input  logic signed [31:0]           i_dir_z,
    input  logic [30:0]                  i_half_length,
    input  logic signed [31:0]           i_ball_center_x,
    input  logic signed [31:0]           i_ball_center_y,
    input  logic signed [31:0]           i_ball_center_z,
    input  logic [30:0]                  i_ball_radius,
    output logic                         o_valid,
    output logic [1:0]                   o_hit_count,
    output logic signed [31:0]           o_t_first,
    output logic signed [31:0]           o_t_second,
    output logic signed [31:0]           o_first_x,
    output logic signed [31:0]           o_first_y,
    output logic signed [31:0]           o_first_z,
    output logic signed [31:0]           o_second_x,
    output logic signed [31:0]           o_second_y,
    output logic signed [31:0]           o_second_z
);

    localparam int CW   = ssi_pkg::CW;
    localparam int EW   = ssi_pkg::EW;
    localparam int DW   = ssi_pkg::DW;
    localparam int A0W  = ssi_pkg::A0W;
    localparam int DOTW = ssi_pkg::DOTW;
    localparam int A1W  = ssi_pkg::A1W;
    localparam int ALW  = ssi_pkg::ALW;
    localparam int AHW  = ssi_pkg::AHW;
    localparam int DSW  = ssi_pkg::DSW;
    localparam int QW   = ssi_pkg::QW;
    localparam int SQW  = ssi_pkg::SQW;
    localparam int NSQ  = ssi_pkg::NSQ;
    localparam int RTW  = ssi_pkg::RTW;
    localparam int REMW = ssi_pkg::REMW;
    localparam int TW   = ssi_pkg::TW;
    localparam int PW   = ssi_pkg::PW;

    logic [CW-1:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= ssi_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign o_busy = 1'b0;

    // ---------------- stage 1: capture request ----------------
    logic             r_s1_v;
    ssi_pkg::t_geo    r_s1_g;
    logic signed [CW-1:0] r_s1_bx, r_s1_by, r_s1_bz;
    logic [EW-1:0]    r_s1_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_v <= 1'b0;
        else          r_s1_v <= i_start;
    end

    always_ff @(posedge i_clk) begin
        r_s1_g.ox <= i_seg_center_x;
        r_s1_g.oy <= i_seg_center_y;
        r_s1_g.oz <= i_seg_center_z;
        r_s1_g.dx <= i_dir_x;
        r_s1_g.dy <= i_dir_y;
        r_s1_g.dz <= i_dir_z;
        r_s1_g.e  <= i_half_length;
        r_s1_bx   <= i_ball_center_x;
        r_s1_by   <= i_ball_center_y;
        r_s1_bz   <= i_ball_center_z;
        r_s1_r    <= i_ball_radius;
    end

    // ---------------- stage 2: centre difference ----------------
    logic             r_s2_v;
    ssi_pkg::t_geo    r_s2_g;
    logic signed [DW-1:0] r_s2_dx, r_s2_dy, r_s2_dz;
    logic [EW-1:0]    r_s2_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s2_v <= 1'b0;
        else          r_s2_v <= r_s1_v;
    end

    always_ff @(posedge i_clk) begin
        r_s2_g  <= r_s1_g;
        r_s2_dx <= DW'(r_s1_g.ox) - DW'(r_s1_bx);
        r_s2_dy <= DW'(r_s1_g.oy) - DW'(r_s1_by);
        r_s2_dz <= DW'(r_s1_g.oz) - DW'(r_s1_bz);
        r_s2_r  <= r_s1_r;
    end

    // ---------------- stage 3: products ----------------
    logic             r_s3_v;
    ssi_pkg::t_geo    r_s3_g;
    logic signed [2*DW-1:0]    r_s3_ddx, r_s3_ddy, r_s3_ddz;
    logic signed [CW+DW-1:0]   r_s3_pdx, r_s3_pdy, r_s3_pdz;
    logic [2*EW-1:0]           r_s3_rr, r_s3_ee;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s3_v <= 1'b0;
        else          r_s3_v <= r_s2_v;
    end

    always_ff @(posedge i_clk) begin
        r_s3_g   <= r_s2_g;
        r_s3_ddx <= r_s2_dx * r_s2_dx;
        r_s3_ddy <= r_s2_dy * r_s2_dy;
        r_s3_ddz <= r_s2_dz * r_s2_dz;
        r_s3_pdx <= r_s2_g.dx * r_s2_dx;
        r_s3_pdy <= r_s2_g.dy * r_s2_dy;
        r_s3_pdz <= r_s2_g.dz * r_s2_dz;
        r_s3_rr  <= r_s2_r * r_s2_r;
        r_s3_ee  <= r_s2_g.e * r_s2_g.e;
    end

    // ---------------- stage 4: A0 and dot ----------------
    logic             r_s4_v;
    ssi_pkg::t_geo    r_s4_g;
    logic signed [A0W-1:0]  r_s4_a0;
    logic signed [DOTW-1:0] r_s4_dot;
    logic [2*EW-1:0]        r_s4_ee;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s4_v <= 1'b0;
        else          r_s4_v <= r_s3_v;
    end

    always_ff @(posedge i_clk) begin
        r_s4_g   <= r_s3_g;
        r_s4_a0  <= A0W'(r_s3_ddx) + A0W'(r_s3_ddy) + A0W'(r_s3_ddz)
                    - $signed(A0W'(r_s3_rr));
        r_s4_dot <= DOTW'(r_s3_pdx) + DOTW'(r_s3_pdy) + DOTW'(r_s3_pdz);
        r_s4_ee  <= r_s3_ee;
    end

    // ---------------- stage 5: round dot to A1 ----------------
    logic             r_s5_v;
    ssi_pkg::t_geo    r_s5_g;
    logic signed [A0W-1:0] r_s5_a0;
    logic signed [A1W-1:0] r_s5_a1;
    logic [2*EW-1:0]       r_s5_ee;
    logic signed [DOTW:0]  n_s5_dr;

    assign n_s5_dr = (DOTW+1)'(r_s4_dot) + (DOTW+1)'(64'sd536870912);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s5_v <= 1'b0;
        else          r_s5_v <= r_s4_v;
    end

    always_ff @(posedge i_clk) begin
        r_s5_g  <= r_s4_g;
        r_s5_a0 <= r_s4_a0;
        r_s5_a1 <= n_s5_dr[DOTW:30];
        r_s5_ee <= r_s4_ee;
    end

    // ---------------- stage 6: partial products of A1*A1 and A1*e ----------------
    // A1 is split into a signed high slice and an unsigned low slice
    logic             r_s6_v;
    ssi_pkg::t_geo    r_s6_g;
    logic signed [A0W-1:0]     r_s6_a0;
    logic signed [A1W-1:0]     r_s6_a1;
    logic [2*EW-1:0]           r_s6_ee;
    logic signed [2*AHW-1:0]   r_s6_hh, r_s6_hl;
    logic [2*ALW-1:0]          r_s6_ll;
    logic signed [AHW+EW:0]    r_s6_he;
    logic [ALW+EW-1:0]         r_s6_le;
    logic signed [AHW-1:0]     n_s6_ah;
    logic [ALW-1:0]            n_s6_al;

    assign n_s6_ah = r_s5_a1[A1W-1:ALW];
    assign n_s6_al = r_s5_a1[ALW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s6_v <= 1'b0;
        else          r_s6_v <= r_s5_v;
    end

    always_ff @(posedge i_clk) begin
        r_s6_g    <= r_s5_g;
        r_s6_a0   <= r_s5_a0;
        r_s6_a1   <= r_s5_a1;
        r_s6_ee   <= r_s5_ee;
        r_s6_hh   <= n_s6_ah * n_s6_ah;
        r_s6_hl   <= n_s6_ah * $signed({1'b0, n_s6_al});
        r_s6_ll   <= n_s6_al * n_s6_al;
        r_s6_he   <= n_s6_ah * $signed({1'b0, r_s5_g.e});
        r_s6_le   <= n_s6_al * r_s5_g.e;
    end

    // ---------------- stage 7: discriminant, e*e + A0, 2*A1*e ----------------
    logic             r_s7_v;
    ssi_pkg::t_geo    r_s7_g;
    logic signed [A1W-1:0] r_s7_a1;
    logic signed [DSW-1:0] r_s7_discr;
    logic signed [QW-1:0]  r_s7_tmp0, r_s7_tmp1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s7_v <= 1'b0;
        else          r_s7_v <= r_s6_v;
    end

    always_ff @(posedge i_clk) begin
        r_s7_g     <= r_s6_g;
        r_s7_a1    <= r_s6_a1;
        r_s7_discr <= (DSW'(r_s6_hh) <<< (2 * ALW)) + (DSW'(r_s6_hl) <<< (ALW + 1))
                      + DSW'($signed({1'b0, r_s6_ll})) - DSW'(r_s6_a0);
        r_s7_tmp0  <= QW'($signed({1'b0, r_s6_ee})) + QW'(r_s6_a0);
        r_s7_tmp1  <= ((QW'(r_s6_he) <<< ALW) + QW'($signed({1'b0, r_s6_le}))) <<< 1;
    end

    // ---------------- stage 8 and square root pipeline ----------------
    logic             r_sq_v  [0:NSQ];
    ssi_pkg::t_geo    r_sq_g  [0:NSQ];
    ssi_pkg::t_cls    r_sq_c  [0:NSQ];
    logic [SQW-1:0]   r_sq_op [0:NSQ];
    logic [RTW-1:0]   r_sq_rt [0:NSQ];
    logic [REMW-1:0]  r_sq_rm [0:NSQ];

    logic signed [QW-1:0] n_s8_qm, n_s8_qp;
    logic                 n_s8_dneg;
    ssi_pkg::t_cls        n_s8_c;

    assign n_s8_qm   = r_s7_tmp0 - r_s7_tmp1;
    assign n_s8_qp   = r_s7_tmp0 + r_s7_tmp1;
    assign n_s8_dneg = r_s7_discr[DSW-1];

    always_comb begin
        n_s8_c.a1      = r_s7_a1;
        n_s8_c.dneg    = n_s8_dneg;
        n_s8_c.thr_ok  = r_s7_discr >= DSW'($signed({1'b0, r_thr}));
        n_s8_c.qm_zero = (n_s8_qm == '0);
        n_s8_c.qm_neg  = n_s8_qm[QW-1];
        n_s8_c.qp_zero = (n_s8_qp == '0);
        n_s8_c.qp_neg  = n_s8_qp[QW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_v[0] <= 1'b0;
        else          r_sq_v[0] <= r_s7_v;
    end

    always_ff @(posedge i_clk) begin
        r_sq_g[0]  <= r_s7_g;
        r_sq_c[0]  <= n_s8_c;
        r_sq_op[0] <= n_s8_dneg ? '0 : r_s7_discr[SQW-1:0];
        r_sq_rt[0] <= '0;
        r_sq_rm[0] <= '0;
    end

    // restoring square root, two operand bits in and one root bit out per stage
    for (genvar gi = 0; gi < NSQ; gi++) begin : g_sqrt
        localparam int P = 2 * (NSQ - 1 - gi);
        logic [REMW-1:0] n_rem;
        logic [REMW-1:0] n_trial;
        logic            n_bit;

        assign n_rem   = {r_sq_rm[gi][REMW-3:0], r_sq_op[gi][P+1:P]};
        assign n_trial = {1'b0, r_sq_rt[gi], 2'b01};
        assign n_bit   = (n_rem >= n_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sq_v[gi+1] <= 1'b0;
            else          r_sq_v[gi+1] <= r_sq_v[gi];
        end

        always_ff @(posedge i_clk) begin
            r_sq_g[gi+1]  <= r_sq_g[gi];
            r_sq_c[gi+1]  <= r_sq_c[gi];
            r_sq_op[gi+1] <= r_sq_op[gi];
            r_sq_rt[gi+1] <= {r_sq_rt[gi][RTW-2:0], n_bit};
            r_sq_rm[gi+1] <= n_bit ? (n_rem - n_trial) : n_rem;
        end
    end

    // ---------------- hit selection ----------------
    ssi_pkg::t_cls        w_c;
    logic signed [TW-1:0] w_a1, w_na, w_ex, w_en, w_rt, w_tm, w_tp, w_abs;
    logic                 w_qm_pos;
    logic [1:0]           n_d_n;
    logic signed [TW-1:0] n_d_t0, n_d_t1;

    assign w_c      = r_sq_c[NSQ];
    assign w_a1     = TW'(w_c.a1);
    assign w_na     = -w_a1;
    assign w_ex     = $signed(TW'(r_sq_g[NSQ].e));
    assign w_en     = -w_ex;
    assign w_rt     = $signed(TW'(r_sq_rt[NSQ]));
    assign w_tm     = w_na - w_rt;
    assign w_tp     = w_na + w_rt;
    assign w_abs    = w_a1[TW-1] ? w_na : w_a1;
    assign w_qm_pos = !w_c.qm_neg && !w_c.qm_zero;

    always_comb begin
        n_d_n  = ssi_pkg::HITS_NONE;
        n_d_t0 = '0;
        n_d_t1 = '0;
        if (!w_c.dneg) begin
            if (w_c.qm_zero && w_c.qp_zero) begin
                n_d_t0 = w_en;
                n_d_t1 = w_ex;
                n_d_n  = ssi_pkg::HITS_TWO;
            end else if (w_c.qm_zero) begin
                n_d_t0 = w_en;
                if (!w_c.qp_neg && w_c.thr_ok && (w_a1 < w_ex)) begin
                    n_d_t1 = w_tp;
                    n_d_n  = ssi_pkg::HITS_TWO;
                end else begin
                    n_d_n  = ssi_pkg::HITS_ONE;
                end
            end else if (w_c.qp_zero) begin
                if (!w_c.qm_neg && w_c.thr_ok && (w_na < w_ex)) begin
                    n_d_t0 = w_tm;
                    n_d_t1 = w_ex;
                    n_d_n  = ssi_pkg::HITS_TWO;
                end else begin
                    n_d_t0 = w_ex;
                    n_d_n  = ssi_pkg::HITS_ONE;
                end
            end else if (w_c.qm_neg != w_c.qp_neg) begin
                n_d_t0 = w_qm_pos ? w_tm : w_tp;
                n_d_n  = ssi_pkg::HITS_ONE;
            end else if (w_qm_pos && (w_abs < w_ex)) begin
                if (w_c.thr_ok) begin
                    n_d_t0 = w_tm;
                    n_d_t1 = w_tp;
                    n_d_n  = ssi_pkg::HITS_TWO;
                end else begin
                    n_d_t0 = w_na;
                    n_d_n  = ssi_pkg::HITS_ONE;
                end
            end
        end
    end

    logic                 r_d_v;
    ssi_pkg::t_geo        r_d_g;
    logic [1:0]           r_d_n;
    logic signed [CW-1:0] r_d_t0, r_d_t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_d_v <= 1'b0;
        else          r_d_v <= r_sq_v[NSQ];
    end

    always_ff @(posedge i_clk) begin
        r_d_g  <= r_sq_g[NSQ];
        r_d_n  <= n_d_n;
        r_d_t0 <= ssi_pkg::sat32(n_d_t0);
        r_d_t1 <= ssi_pkg::sat32(n_d_t1);
    end

    // ---------------- parameter times direction ----------------
    logic                 r_m_v;
    ssi_pkg::t_geo        r_m_g;
    logic [1:0]           r_m_n;
    logic signed [CW-1:0] r_m_t0, r_m_t1;
    logic signed [PW-1:0] r_m_p0x, r_m_p0y, r_m_p0z, r_m_p1x, r_m_p1y, r_m_p1z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_m_v <= 1'b0;
        else          r_m_v <= r_d_v;
    end

    always_ff @(posedge i_clk) begin
        r_m_g   <= r_d_g;
        r_m_n   <= r_d_n;
        r_m_t0  <= r_d_t0;
        r_m_t1  <= r_d_t1;
        r_m_p0x <= r_d_t0 * r_d_g.dx;
        r_m_p0y <= r_d_t0 * r_d_g.dy;
        r_m_p0z <= r_d_t0 * r_d_g.dz;
        r_m_p1x <= r_d_t1 * r_d_g.dx;
        r_m_p1y <= r_d_t1 * r_d_g.dy;
        r_m_p1z <= r_d_t1 * r_d_g.dz;
    end

    // ---------------- points and output register ----------------
    logic n_use0, n_use1;

    assign n_use0 = (r_m_n != ssi_pkg::HITS_NONE);
    assign n_use1 = (r_m_n == ssi_pkg::HITS_TWO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_m_v;
    end

    always_ff @(posedge i_clk) begin
        o_hit_count <= r_m_n;
        o_t_first   <= n_use0 ? r_m_t0 : '0;
        o_t_second  <= n_use1 ? r_m_t1 : '0;
        o_first_x   <= n_use0 ? ssi_pkg::hit_point(r_m_g.ox, r_m_p0x) : '0;
        o_first_y   <= n_use0 ? ssi_pkg::hit_point(r_m_g.oy, r_m_p0y) : '0;
        o_first_z   <= n_use0 ? ssi_pkg::hit_point(r_m_g.oz, r_m_p0z) : '0;
        o_second_x  <= n_use1 ? ssi_pkg::hit_point(r_m_g.ox, r_m_p1x) : '0;
        o_second_y  <= n_use1 ? ssi_pkg::hit_point(r_m_g.oy, r_m_p1y) : '0;
        o_second_z  <= n_use1 ? ssi_pkg::hit_point(r_m_g.oz, r_m_p1z) : '0;
    end

    // ---------------- checks ----------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hit_count != 2'd3))
        else $error("hit count out of range");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count == ssi_pkg::HITS_NONE) |->
        (o_t_first == '0 && o_first_x == '0 && o_first_y == '0 && o_first_z == '0))
        else $error("first hit fields set with no hits");

    a_second_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit_count != ssi_pkg::HITS_TWO) |->
        (o_t_second == '0 && o_second_x == '0 && o_second_y == '0 && o_second_z == '0))
        else $error("second hit fields set with fewer than two hits");

    a_neg_discr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sq_v[NSQ] && r_sq_c[NSQ].dneg) |=> (r_d_n == ssi_pkg::HITS_NONE))
        else $error("hit reported with negative discriminant");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_v |=> o_valid)
        else $error("request lost at output stage");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for segment_sphere_intersect_unit. A queue of requests
// (directed corner cases, then random segments and spheres) feeds a clocked
// driver with random gaps. Each accepted request is run through a bit-exact
// fixed-point intersect model. A monitor compares every result against the
// oldest predicted hit record. The tolerance register is swept over several
// values between phases, always with the pipe empty.
// ----------------------------------------------------------------------------
module testbench;

    localparam int  LIMIT  = 400000;
    localparam int  ONE_Q30 = 1 << 30;

    typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_DRAIN} t_act;

    typedef struct {
        t_act               act;
        int                 gap;
        logic [31:0]        cfg_val;
        logic signed [31:0] sx, sy, sz, dx, dy, dz, bx, by, bz;
        logic [30:0]        e, r;
    } t_seg_req;

    typedef struct {
        logic [1:0]         hits;
        logic signed [31:0] ta, tb;
        logic signed [31:0] pa[3];
        logic signed [31:0] pb[3];
    } t_hit_rec;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               o_busy;
    logic               i_cfg_we = 1'b0;
    logic [31:0]        i_cfg_wdata = '0;
    logic signed [31:0] i_seg_center_x = '0, i_seg_center_y = '0, i_seg_center_z = '0;
    logic signed [31:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [30:0]        i_half_length = '0;
    logic signed [31:0] i_ball_center_x = '0, i_ball_center_y = '0, i_ball_center_z = '0;
    logic [30:0]        i_ball_radius = '0;
    logic               o_valid;
    logic [1:0]         o_hit_count;
    logic signed [31:0] o_t_first, o_t_second;
    logic signed [31:0] o_first_x, o_first_y, o_first_z;
    logic signed [31:0] o_second_x, o_second_y, o_second_z;

    t_seg_req    pending[$];
    t_hit_rec    hits_due[$];
    t_seg_req    cur_req;
    logic [31:0] tol_reg = ssi_pkg::THR_RESET;
    int          gap_left = 0;
    int          errors = 0;
    int          cycles = 0;

    always #4 i_clk = ~i_clk;

    segment_sphere_intersect_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_seg_center_x(i_seg_center_x), .i_seg_center_y(i_seg_center_y),
        .i_seg_center_z(i_seg_center_z),
        .i_dir_x(i_dir_x), .i_dir_y(i_dir_y), .i_dir_z(i_dir_z),
        .i_half_length(i_half_length),
        .i_ball_center_x(i_ball_center_x), .i_ball_center_y(i_ball_center_y),
        .i_ball_center_z(i_ball_center_z), .i_ball_radius(i_ball_radius),
        .o_valid(o_valid), .o_hit_count(o_hit_count),
        .o_t_first(o_t_first), .o_t_second(o_t_second),
        .o_first_x(o_first_x), .o_first_y(o_first_y), .o_first_z(o_first_z),
        .o_second_x(o_second_x), .o_second_y(o_second_y), .o_second_z(o_second_z)
    );

    function automatic longint clip_q16(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // centre + round-half-up(t * dir) back to Q16.16
    function automatic logic signed [31:0] place_point(longint org, longint ts, longint dir);
        longint p;
        p = ts * dir + (64'sd1 <<< 29);
        return 32'(clip_q16(org + (p >>> 30)));
    endfunction

    function automatic t_hit_rec solve_hits(t_seg_req q, logic [31:0] tol);
        longint              org[3], dv[3], dd[3];
        longint              e, r, a1, root, c, t0, t1, ta, tb, aa;
        logic signed [127:0] a0, dot, discr, tmp0, tmp1, qm, qp, w, v;
        bit                  thr_ok;
        logic [1:0]          n;
        t_hit_rec            res;
        org = '{longint'(q.sx), longint'(q.sy), longint'(q.sz)};
        dv  = '{longint'(q.dx), longint'(q.dy), longint'(q.dz)};
        dd  = '{org[0] - longint'(q.bx), org[1] - longint'(q.by), org[2] - longint'(q.bz)};
        e = longint'(q.e);
        r = longint'(q.r);
        a0 = 0;
        dot = 0;
        for (int k = 0; k < 3; k++) begin
            w = dd[k];
            v = dv[k];
            a0 += w * w;
            dot += v * w;
        end
        w = r;
        a0 -= w * w;
        dot = (dot + (128'sd1 <<< 29)) >>> 30;
        a1 = longint'(dot);
        w = a1;
        discr = w * w - a0;
        n = ssi_pkg::HITS_NONE;
        t0 = 0;
        t1 = 0;
        if (discr >= 0) begin
            root = 0;
            for (int b = 36; b >= 0; b--) begin
                c = root | (64'sd1 <<< b);
                w = c;
                if (w * w <= discr) root = c;
            end
            w = longint'({32'd0, tol});
            thr_ok = discr >= w;
            w = e;
            v = 2 * a1;
            tmp0 = w * w + a0;
            tmp1 = v * w;
            qm = tmp0 - tmp1;
            qp = tmp0 + tmp1;
            aa = a1 < 0 ? -a1 : a1;
            if (qm == 0 && qp == 0) begin
                t0 = -e; t1 = e; n = ssi_pkg::HITS_TWO;
            end else if (qm == 0) begin
                if (qp >= 0 && thr_ok && a1 < e) begin
                    t0 = -e; t1 = -a1 + root; n = ssi_pkg::HITS_TWO;
                end else begin
                    t0 = -e; n = ssi_pkg::HITS_ONE;
                end
            end else if (qp == 0) begin
                if (qm >= 0 && thr_ok && -a1 < e) begin
                    t0 = -a1 - root; t1 = e; n = ssi_pkg::HITS_TWO;
                end else begin
                    t0 = e; n = ssi_pkg::HITS_ONE;
                end
            end else if ((qm < 0) != (qp < 0)) begin
                t0 = qm > 0 ? -a1 - root : -a1 + root;
                n = ssi_pkg::HITS_ONE;
            end else if (qm > 0 && aa < e) begin
                if (thr_ok) begin
                    t0 = -a1 - root; t1 = -a1 + root; n = ssi_pkg::HITS_TWO;
                end else begin
                    t0 = -a1; n = ssi_pkg::HITS_ONE;
                end
            end
        end
        res.hits = n;
        res.ta = '0;
        res.tb = '0;
        res.pa = '{0, 0, 0};
        res.pb = '{0, 0, 0};
        if (n != ssi_pkg::HITS_NONE) begin
            ta = clip_q16(t0);
            res.ta = 32'(ta);
            for (int k = 0; k < 3; k++) res.pa[k] = place_point(org[k], ta, dv[k]);
        end
        if (n == ssi_pkg::HITS_TWO) begin
            tb = clip_q16(t1);
            res.tb = 32'(tb);
            for (int k = 0; k < 3; k++) res.pb[k] = place_point(org[k], tb, dv[k]);
        end
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        if (got != want) begin
            errors++;
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    // ---- driver ----
    always @(posedge i_clk) begin
        logic     start_n;
        logic     we_n;
        t_seg_req hd;
        start_n = i_start;
        we_n = 1'b0;
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                hits_due.push_back(solve_hits(cur_req, tol_reg));
                start_n = 1'b0;
            end
            if (!start_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0) begin
                    hd = pending[0];
                    case (hd.act)
                        ACT_REQ: begin
                            pending.pop_front();
                            cur_req = hd;
                            gap_left = hd.gap;
                            start_n = 1'b1;
                            i_seg_center_x  <= hd.sx;
                            i_seg_center_y  <= hd.sy;
                            i_seg_center_z  <= hd.sz;
                            i_dir_x         <= hd.dx;
                            i_dir_y         <= hd.dy;
                            i_dir_z         <= hd.dz;
                            i_half_length   <= hd.e;
                            i_ball_center_x <= hd.bx;
                            i_ball_center_y <= hd.by;
                            i_ball_center_z <= hd.bz;
                            i_ball_radius   <= hd.r;
                        end
                        ACT_CFG: if (hits_due.size() == 0) begin
                            pending.pop_front();
                            we_n = 1'b1;
                            i_cfg_wdata <= hd.cfg_val;
                            tol_reg = hd.cfg_val;
                        end
                        default: if (hits_due.size() == 0) pending.pop_front();
                    endcase
                end
            end
        end
        i_start  <= start_n;
        i_cfg_we <= we_n;
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        t_hit_rec x;
        if (i_rst_n && o_valid) begin
            if (hits_due.size() == 0) begin
                errors++;
                $display("%0t unexpected result", $realtime);
            end else begin
                x = hits_due.pop_front();
                report("hit_count", o_hit_count, x.hits);
                report("t_first", o_t_first, x.ta);
                report("t_second", o_t_second, x.tb);
                report("first_x", o_first_x, x.pa[0]);
                report("first_y", o_first_y, x.pa[1]);
                report("first_z", o_first_z, x.pa[2]);
                report("second_x", o_second_x, x.pb[0]);
                report("second_y", o_second_y, x.pb[1]);
                report("second_z", o_second_z, x.pb[2]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---- stimulus ----
    function automatic int srand(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    task automatic push_req(int sx, int sy, int sz, int dx, int dy, int dz, int e,
                            int bx, int by, int bz, int r, int gap);
        t_seg_req q;
        q.act = ACT_REQ;
        q.gap = gap;
        q.cfg_val = '0;
        q.sx = sx; q.sy = sy; q.sz = sz;
        q.dx = dx; q.dy = dy; q.dz = dz;
        q.bx = bx; q.by = by; q.bz = bz;
        q.e = 31'(e);
        q.r = 31'(r);
        pending.push_back(q);
    endtask

    task automatic push_ctl(t_act a, logic [31:0] val);
        t_seg_req q;
        q.act = a;
        q.gap = 0;
        q.cfg_val = val;
        q.sx = '0; q.sy = '0; q.sz = '0;
        q.dx = '0; q.dy = '0; q.dz = '0;
        q.bx = '0; q.by = '0; q.bz = '0;
        q.e = '0;
        q.r = '0;
        pending.push_back(q);
    endtask

    task automatic push_random(int gap);
        int b[3], s[3], dv[3], r, e, sel;
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
            // any centres, half-length and radius the ports allow; direction components up to one in magnitude
            push_req($urandom, $urandom, $urandom, srand(ONE_Q30), srand(ONE_Q30),
                     srand(ONE_Q30), $urandom, $urandom, $urandom, $urandom,
                     $urandom, gap);
        end else begin
            for (int k = 0; k < 3; k++) b[k] = srand(1 << 24);
            r = $urandom_range(0, 1 << 22);
            if ($urandom_range(0, 1)) begin
                dv = '{0, 0, 0};
                dv[$urandom_range(0, 2)] = $urandom_range(0, 1) ? ONE_Q30 : -ONE_Q30;
            end else begin
                for (int k = 0; k < 3; k++) dv[k] = srand(ONE_Q30);
            end
            if (sel < 45) begin
                // grazing line along x, or an endpoint sitting on the surface
                dv = '{ONE_Q30, 0, 0};
                e = $urandom_range(0, 1 << 22);
                if ($urandom_range(0, 1))
                    s = '{b[0] + srand(1 << 20), b[1] + r + srand(3), b[2]};
                else
                    s = '{b[0] + ($urandom_range(0, 1) ? r - e : e - r), b[1], b[2]};
            end else begin
                for (int k = 0; k < 3; k++) s[k] = b[k] + srand(2 * r + 4);
                e = $urandom_range(0, 3 * r + 4);
            end
            push_req(s[0], s[1], s[2], dv[0], dv[1], dv[2], e, b[0], b[1], b[2], r, gap);
        end
    endtask

    initial begin
        logic [31:0] tols[5];
        int          gap, burst;
        tols = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1, ssi_pkg::THR_RESET};

        // directed corners
        push_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        push_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE_Q30, ONE_Q30, ONE_Q30,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 0);
        push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -ONE_Q30, -ONE_Q30,
                 -ONE_Q30, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 0, 1);
        push_req(32'h8000_0000, 0, 0, ONE_Q30, 0, 0, 32'h7FFF_FFFF, 0, 0, 0,
                 32'h7FFF_FFFF, 0);
        // straight through: two hits
        push_req(0, 0, 0, ONE_Q30, 0, 0, 5 << 16, 0, 0, 0, 2 << 16, 0);
        // fully inside: none
        push_req(0, 0, 0, 0, ONE_Q30, 0, 1 << 16, 0, 0, 0, 4 << 16, 2);
        // one endpoint inside
        push_req(3 << 16, 0, 0, -ONE_Q30, 0, 0, 3 << 16, 0, 0, 0, 2 << 16, 0);
        push_req(-(3 << 16), 0, 0, -ONE_Q30, 0, 0, 3 << 16, 0, 0, 0, 2 << 16, 0);
        // clear miss and segment short of the sphere
        push_req(0, 10 << 16, 0, ONE_Q30, 0, 0, 5 << 16, 0, 0, 0, 2 << 16, 3);
        push_req(10 << 16, 0, 0, ONE_Q30, 0, 0, 1 << 16, 0, 0, 0, 2 << 16, 0);
        // tangent and near tangent
        push_req(0, 2 << 16, 0, ONE_Q30, 0, 0, 5 << 16, 0, 0, 0, 2 << 16, 0);
        push_req(0, (2 << 16) - 1, 0, ONE_Q30, 0, 0, 5 << 16, 0, 0, 0, 2 << 16, 0);
        push_req(0, (2 << 16) - 40, 0, ONE_Q30, 0, 0, 5 << 16, 0, 0, 0, 2 << 16, 0);
        // an endpoint exactly on the surface, each end, and both ends on it
        push_req(1 << 16, 0, 0, ONE_Q30, 0, 0, 1 << 16, 0, 0, 0, 2 << 16, 0);
        push_req(-(1 << 16), 0, 0, ONE_Q30, 0, 0, 1 << 16, 0, 0, 0, 2 << 16, 0);
        push_req(3 << 16, 0, 0, ONE_Q30, 0, 0, 1 << 16, 0, 0, 0, 2 << 16, 0);
        push_req(0, 0, 0, ONE_Q30, 0, 0, 2 << 16, 0, 0, 0, 2 << 16, 0);
        // zero length, zero radius, non-unit direction
        push_req(1 << 16, 0, 0, ONE_Q30, 0, 0, 0, 0, 0, 0, 1 << 16, 0);
        push_req(0, 0, 0, ONE_Q30, 0, 0, 3 << 16, 1 << 16, 0, 0, 0, 0);
        push_req(0, 0, 0, ONE_Q30 / 3, ONE_Q30, -ONE_Q30, 6 << 16, 0, 0, 0, 2 << 16, 0);

        // random phases, tolerance changed with the pipe drained
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) push_ctl(ACT_CFG, tols[ph - 1]);
            burst = 0;
            for (int i = 0; i < 240; i++) begin
                if (i % 40 == 0) burst = $urandom_range(0, 2) == 0;
                if (i == 120) push_ctl(ACT_DRAIN, '0);
                gap = burst ? 0 : $urandom_range(0, 17);
                push_random(gap);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending.size() == 0);
        @(posedge i_clk);
        while (i_start || hits_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
hdl/ssi_pkg.sv
hdl/segment_sphere_intersect_unit.sv
dv/testbench.sv
